FILE: rtl/core/pic_pkg.sv
// pic_pkg: shared types and codes for the interrupt controller register interface.
// Used by pic_prio_enc, pic_core and pic_register_interface; depends on nothing.

package pic_pkg;

	localparam int unsigned LINES     = 8;
	localparam int unsigned LINE_W    = 3;
	localparam int unsigned BASE_W    = 5;

	localparam logic [7:0]  MASK_RESET = 8'hFF;
	localparam logic [4:0]  BASE_RESET = 5'd1;

	// upper three bits of an OCW2 byte
	localparam logic [2:0]  EOI_SPECIFIC = 3'b011;
	localparam logic [2:0]  EOI_NONSPEC  = 3'b001;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RAISE = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_ICW2  = 5'b00010,
		PH_ICW3  = 5'b00100,
		PH_ICW4  = 5'b01000,
		PH_READY = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       port_select;
		logic [7:0] write_data;
		logic [7:0] request_lines;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       ack_valid;
		logic [7:0] vector;
		logic       int_pending;
	} rsp_t;

	typedef struct packed {
		logic              found;
		logic [LINE_W-1:0] line;
		logic [LINES-1:0]  grant;
	} prio_t;

endpackage

FILE: rtl/core/pic_prio_enc.sv
// pic_prio_enc: lowest-numbered-line priority encoder over the eligible lines.
// Depends on pic_pkg for the line count and the prio_t result struct.

module pic_prio_enc (
	input  logic [pic_pkg::LINES-1:0] eligible,
	output pic_pkg::prio_t            prio
);

	always_comb begin
		prio.found = 1'b0;
		prio.line  = '0;
		prio.grant = '0;
		for (int i = pic_pkg::LINES - 1; i >= 0; i--) begin
			if (eligible[i]) begin
				prio.found = 1'b1;
				prio.line  = pic_pkg::LINE_W'(i);
				prio.grant = pic_pkg::LINES'(1) << i;
			end
		end
	end

endmodule

FILE: rtl/core/pic_core.sv
// pic_core: controller registers, operation decode and the result of one word.
// Depends on pic_pkg and instantiates pic_prio_enc.

module pic_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  pic_pkg::req_t req,
	output pic_pkg::rsp_t rsp
);

	logic [7:0]       request_q, service_q, mask_q, icw1_q;
	logic             show_service_q;
	pic_pkg::phase_t  phase_q;
	logic [4:0]       base_q;

	logic [7:0]       request_d, service_d, mask_d, icw1_d;
	logic             show_service_d;
	pic_pkg::phase_t  phase_d, after_three;
	logic [4:0]       base_d;
	logic [7:0]       eoi_bit;
	pic_pkg::prio_t   prio;

	pic_prio_enc u_prio (
		.eligible (request_q & ~mask_q & ~service_q),
		.prio     (prio)
	);

	always_comb begin
		request_d      = request_q;
		service_d      = service_q;
		mask_d         = mask_q;
		icw1_d         = icw1_q;
		show_service_d = show_service_q;
		phase_d        = phase_q;
		base_d         = base_q;
		eoi_bit        = 8'(1) << req.write_data[2:0];
		after_three    = icw1_q[0] ? pic_pkg::PH_ICW4 : pic_pkg::PH_READY;
		rsp            = '0;
		case (pic_pkg::op_t'(req.opcode))
			pic_pkg::OP_READ: begin
				if (req.port_select)
					rsp.read_data = mask_q;
				else
					rsp.read_data = show_service_q ? service_q : request_q;
			end
			pic_pkg::OP_WRITE: begin
				if (!req.port_select) begin
					if (req.write_data[4]) begin
						mask_d         = '0;
						icw1_d         = req.write_data;
						phase_d        = pic_pkg::PH_ICW2;
						show_service_d = 1'b0;
					end else if (!req.write_data[3]) begin
						if (req.write_data[7:5] == pic_pkg::EOI_SPECIFIC) begin
							request_d = request_q & ~eoi_bit;
							service_d = service_q & ~eoi_bit;
						end else if (req.write_data[7:5] == pic_pkg::EOI_NONSPEC) begin
							request_d = request_q & ~service_q;
							service_d = '0;
						end
					end else if (req.write_data[1]) begin
						show_service_d = req.write_data[0];
					end
				end else begin
					case (phase_q)
						pic_pkg::PH_ICW2: begin
							base_d  = req.write_data[7:3];
							phase_d = icw1_q[1] ? after_three : pic_pkg::PH_ICW3;
						end
						pic_pkg::PH_ICW3:  phase_d = after_three;
						pic_pkg::PH_ICW4:  phase_d = pic_pkg::PH_READY;
						pic_pkg::PH_READY: mask_d  = req.write_data;
						default: ;
					endcase
				end
			end
			pic_pkg::OP_RAISE: begin
				request_d = request_q | req.request_lines;
			end
			default: begin
				if (prio.found) begin
					service_d     = service_q | prio.grant;
					rsp.ack_valid = 1'b1;
					rsp.vector    = {base_q, prio.line};
				end
			end
		endcase
		rsp.int_pending = |(request_d & ~mask_d & ~service_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_q      <= '0;
			service_q      <= '0;
			mask_q         <= pic_pkg::MASK_RESET;
			icw1_q         <= '0;
			show_service_q <= 1'b0;
			phase_q        <= pic_pkg::PH_IDLE;
			base_q         <= pic_pkg::BASE_RESET;
		end else if (step) begin
			request_q      <= request_d;
			service_q      <= service_d;
			mask_q         <= mask_d;
			icw1_q         <= icw1_d;
			show_service_q <= show_service_d;
			phase_q        <= phase_d;
			base_q         <= base_d;
		end
	end

	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(prio.grant))
		else $error("grant has more than one line");

	a_ack_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.ack_valid |-> (prio.found && req.opcode == pic_pkg::OP_ACK))
		else $error("acknowledge served without an eligible line");

	a_ack_sets_service: assert property (@(posedge clk) disable iff (!arst_n)
		(step && rsp.ack_valid) |=> ((service_q & $past(prio.grant)) != '0))
		else $error("served line not marked in service");

	a_icw1_init: assert property (@(posedge clk) disable iff (!arst_n)
		(step && req.opcode == pic_pkg::OP_WRITE && !req.port_select && req.write_data[4])
		|=> (mask_q == '0 && phase_q == pic_pkg::PH_ICW2 && !show_service_q))
		else $error("ICW1 did not restart initialization");

endmodule

FILE: rtl/core/pic_register_interface.sv
// pic_register_interface: top level, input register, controller core and result register.
// Depends on pic_pkg and instantiates pic_core.
//
//   channel | valid     | ready     | payload
//   req     | req_valid | req_ready | opcode, port_select, write_data, request_lines
//   rsp     | rsp_valid | rsp_ready | read_data, ack_valid, vector, int_pending
//
// One word per cycle sustained while rsp_ready holds; an accepted word goes from the input
// register through the core decode into the result register, whose valid then offers it.
// Reset clears both stage valids and the controller registers, but mask resets to all masked and base to 1.
// A stalled result holds the input register, and req_ready drops only when both are full.

module pic_register_interface (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] opcode,
	input  logic       port_select,
	input  logic [7:0] write_data,
	input  logic [7:0] request_lines,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] read_data,
	output logic       ack_valid,
	output logic [7:0] vector,
	output logic       int_pending
);

	logic          valid_s1, valid_s2, adv_s1;
	pic_pkg::req_t req_s1;
	pic_pkg::rsp_t rsp_s2, rsp_comb;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (adv_s1)
				valid_s2 <= 1'b1;
			else if (rsp_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= '{opcode: opcode, port_select: port_select,
			           write_data: write_data, request_lines: request_lines};
		if (adv_s1)
			rsp_s2 <= rsp_comb;
	end

	pic_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.req    (req_s1),
		.rsp    (rsp_comb)
	);

	assign rsp_valid   = valid_s2;
	assign read_data   = rsp_s2.read_data;
	assign ack_valid   = rsp_s2.ack_valid;
	assign vector      = rsp_s2.vector;
	assign int_pending = rsp_s2.int_pending;

endmodule
